// ===== hw/rtl/eraf_pkg.sv =====
// ----------------------------------------------------------------------------
// eraf_pkg
// Shared types, register indexes, reason codes and the CRC-32 helper of the
// receive address filter.
// ----------------------------------------------------------------------------
`default_nettype none

package eraf_pkg;

  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned HASH_W       = 64;
  localparam int unsigned BIN_W        = 6;
  localparam int unsigned ENTRY_W      = 2;
  localparam int unsigned PHYS_ENTRIES = 4;
  localparam int unsigned ENABLE_W     = 4;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned REASON_W     = 2;
  localparam int unsigned CRC_W        = 32;

  localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PROMISCUOUS         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_ENABLE        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDRESS     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_ADDRESS_ONE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_ADDRESS_TWO   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_ADDRESS_THREE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_HASH          = 3'd6;

  // Filter verdict reasons
  localparam logic [REASON_W-1:0] REASON_REJECT      = 2'd0;
  localparam logic [REASON_W-1:0] REASON_PROMISCUOUS = 2'd1;
  localparam logic [REASON_W-1:0] REASON_EXACT       = 2'd2;
  localparam logic [REASON_W-1:0] REASON_HASH        = 2'd3;

  typedef struct packed {
    logic                                promiscuous;
    logic [ENABLE_W-1:0]                 entry_enable;
    logic [PHYS_ENTRIES-1:0][ADDR_W-1:0] entry_addr;
    logic [HASH_W-1:0]                   group_hash;
  } cfg_t;

  typedef struct packed {
    logic                accept;
    logic [REASON_W-1:0] reason;
    logic [ENTRY_W-1:0]  entry_hit;
    logic [BIN_W-1:0]    hash_bin;
  } result_t;

  // Bitwise Ethernet CRC-32 over the six address bytes, first byte from
  // bits 47..40, each byte LSB first. Used at elaboration only.
  function automatic logic [CRC_W-1:0] crc_bits(input logic [ADDR_W-1:0] addr,
                                                input logic [CRC_W-1:0]  preset);
    logic [CRC_W-1:0] crc;
    logic             fb;
    crc = preset;
    for (int b = 0; b < 6; b++) begin
      for (int k = 0; k < 8; k++) begin
        fb  = crc[CRC_W-1] ^ addr[40 - 8 * b + k];
        crc = {crc[CRC_W-2:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  // Per bin bit: the address bits that feed it through the XOR network
  function automatic logic [BIN_W-1:0][ADDR_W-1:0] bin_masks();
    logic [BIN_W-1:0][ADDR_W-1:0] masks;
    logic [CRC_W-1:0]             crc;
    masks = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      crc = crc_bits(ADDR_W'(1) << i, '0);
      for (int j = 0; j < BIN_W; j++) begin
        masks[j][i] = crc[CRC_W - BIN_W + j];
      end
    end
    return masks;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/eraf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// eraf_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module eraf_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [eraf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [eraf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output eraf_pkg::cfg_t                            cfg
);

  eraf_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        eraf_pkg::REG_PROMISCUOUS: begin
          regs.promiscuous <= cfg_data[0];
        end
        eraf_pkg::REG_ENTRY_ENABLE: begin
          regs.entry_enable <= cfg_data[eraf_pkg::ENABLE_W-1:0];
        end
        eraf_pkg::REG_STATION_ADDRESS: begin
          regs.entry_addr[0] <= cfg_data[eraf_pkg::ADDR_W-1:0];
        end
        eraf_pkg::REG_EXTRA_ADDRESS_ONE: begin
          regs.entry_addr[1] <= cfg_data[eraf_pkg::ADDR_W-1:0];
        end
        eraf_pkg::REG_EXTRA_ADDRESS_TWO: begin
          regs.entry_addr[2] <= cfg_data[eraf_pkg::ADDR_W-1:0];
        end
        eraf_pkg::REG_EXTRA_ADDRESS_THREE: begin
          regs.entry_addr[3] <= cfg_data[eraf_pkg::ADDR_W-1:0];
        end
        eraf_pkg::REG_GROUP_HASH: begin
          regs.group_hash <= cfg_data[eraf_pkg::HASH_W-1:0];
        end
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== hw/rtl/eraf_hash_bin.sv =====
// ----------------------------------------------------------------------------
// eraf_hash_bin
// Top six CRC-32 bits of a destination address as a flat XOR network.
// ----------------------------------------------------------------------------
`default_nettype none

module eraf_hash_bin (
  input  wire logic [eraf_pkg::ADDR_W-1:0] destination,
  output logic      [eraf_pkg::BIN_W-1:0]  hash_bin
);

  localparam logic [eraf_pkg::BIN_W-1:0][eraf_pkg::ADDR_W-1:0] BinMask =
    eraf_pkg::bin_masks();
  localparam logic [eraf_pkg::CRC_W-1:0] PresetCrc =
    eraf_pkg::crc_bits('0, eraf_pkg::CRC_PRESET);

  // CRC is linear: preset contribution plus one parity per bin bit
  always_comb begin
    for (int j = 0; j < eraf_pkg::BIN_W; j++) begin
      hash_bin[j] = (^(destination & BinMask[j]))
                    ^ PresetCrc[eraf_pkg::CRC_W - eraf_pkg::BIN_W + j];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/eraf_classify.sv =====
// ----------------------------------------------------------------------------
// eraf_classify
// Exact-match compare, group hash lookup and priority verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module eraf_classify #(
  parameter int unsigned ADDRESS_ENTRIES = 4
) (
  input  wire logic [eraf_pkg::ADDR_W-1:0] destination,
  input  wire logic [eraf_pkg::BIN_W-1:0]  hash_bin,
  input  eraf_pkg::cfg_t                   cfg,
  output eraf_pkg::result_t                result
);

  // Only the physical entries exist
  localparam int unsigned Compared = (ADDRESS_ENTRIES < eraf_pkg::PHYS_ENTRIES)
                                     ? ADDRESS_ENTRIES : eraf_pkg::PHYS_ENTRIES;

  logic                          matched;
  logic [eraf_pkg::ENTRY_W-1:0]  hit;
  logic                          group;

  always_comb begin
    matched = 1'b0;
    hit     = '0;
    // walk down so the lowest matching entry wins
    for (int i = Compared - 1; i >= 0; i--) begin
      if (cfg.entry_enable[i] && (cfg.entry_addr[i] == destination)) begin
        matched = 1'b1;
        hit     = eraf_pkg::ENTRY_W'(i);
      end
    end
  end

  assign group = destination[40];

  always_comb begin
    if (cfg.promiscuous) begin
      result.reason = eraf_pkg::REASON_PROMISCUOUS;
    end else if (matched) begin
      result.reason = eraf_pkg::REASON_EXACT;
    end else if (group && cfg.group_hash[hash_bin]) begin
      result.reason = eraf_pkg::REASON_HASH;
    end else begin
      result.reason = eraf_pkg::REASON_REJECT;
    end
    result.accept    = (result.reason != eraf_pkg::REASON_REJECT);
    result.entry_hit = hit;
    result.hash_bin  = hash_bin;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ethernet_receive_address_filter.sv =====
// ----------------------------------------------------------------------------
// ethernet_receive_address_filter
// Receive address filter: promiscuous, exact-match entries and a 64-bin
// group hash over the CRC-32 of the destination address.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Width  Contents
//  s_axis    in         48     destination address
//  m_axis    out        16     accept, reason, entry_hit, hash_bin
//  cfg       in         3+64   register index, write data
//
//  One transaction per cycle sustained while m_axis is ready. A transaction
//  passes an input register, then the CRC network and compares into the
//  result register. Reset (rst, synchronous) clears all configuration
//  registers and both valid flags. A stall on m_axis holds the result
//  register; the input register keeps taking a transaction while its
//  content can move on, so the two stages hold up to two transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_receive_address_filter #(
  parameter int unsigned ADDRESS_ENTRIES = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // slave side
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [47:0]                      s_axis_tdata,  // [47:0] destination
  // master side
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [15:0]                           m_axis_tdata,  // [0] accept, [2:1] reason,
                                                               // [4:3] entry_hit,
                                                               // [10:5] hash_bin, [15:11] 0
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [eraf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [eraf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  eraf_pkg::cfg_t    cfg;
  eraf_pkg::result_t result_next;
  eraf_pkg::result_t result;

  logic                         in_valid;
  logic [eraf_pkg::ADDR_W-1:0]  in_destination;
  logic [eraf_pkg::BIN_W-1:0]   hash_bin;
  logic                         out_valid;
  logic                         out_free;
  logic                         in_free;

  eraf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register can load when empty or being drained this cycle
  assign out_free = !out_valid || m_axis_tready;
  // Input register can load when empty or moving into the result register
  assign in_free  = !in_valid || out_free;
  assign s_axis_tready = in_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_axis_tvalid) begin
      in_destination <= s_axis_tdata;
    end
  end

  eraf_hash_bin u_hash_bin (
    .destination (in_destination),
    .hash_bin    (hash_bin)
  );

  eraf_classify #(
    .ADDRESS_ENTRIES (ADDRESS_ENTRIES)
  ) u_classify (
    .destination (in_destination),
    .hash_bin    (hash_bin),
    .cfg         (cfg),
    .result      (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, result.hash_bin, result.entry_hit, result.reason,
                          result.accept};

endmodule

`default_nettype wire
